>>> design/sxlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared/exclusive lock table package
// Sizes, codes and the slot word layout shared by the lock table modules.
// ----------------------------------------------------------------------------
package sxlt_pkg;

	localparam int ENTRIES          = 16;
	localparam int NUM_GATES        = 37;
	localparam int KEY_BITS         = 32;
	localparam int SHARE_COUNT_BITS = 16;

	localparam int FUNC_W   = 2;
	localparam int KEY_IN_W = 32;
	localparam int STATUS_W = 3;
	localparam int GATE_W   = 6;
	localparam int WAIT_W   = 8;

	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int SCAN_W    = $clog2(ENTRIES + 1);
	localparam int GADDR_W   = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
	localparam int CLR_DEPTH = (ENTRIES > NUM_GATES) ? ENTRIES : NUM_GATES;
	localparam int CLR_W     = $clog2(CLR_DEPTH + 1);

	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = (KEY_BITS + MOD_DIGIT - 1) / MOD_DIGIT;
	localparam int MOD_PAD   = MOD_STEPS * MOD_DIGIT;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	typedef enum logic [FUNC_W-1:0] {
		FN_LOCK_EX   = 2'd0,
		FN_LOCK_SH   = 2'd1,
		FN_UNLOCK_EX = 2'd2,
		FN_UNLOCK_SH = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED    = 3'd0,
		ST_BUSY       = 3'd1,
		ST_NOT_LOCKED = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_SHARE_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic                        valid;
		logic [KEY_BITS-1:0]         key;
		logic                        excl;
		logic [SHARE_COUNT_BITS-1:0] count;
	} slot_word_t;

	localparam int SLOT_W = $bits(slot_word_t);

endpackage
`default_nettype wire

>>> design/sxlt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sxlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/sxlt_gate_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gate residue unit
// Reduces the key modulo the gate count, one hex digit per cycle.
// ----------------------------------------------------------------------------
module sxlt_gate_mod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [sxlt_pkg::KEY_BITS-1:0] key,
	output logic                               done,
	output logic      [sxlt_pkg::GATE_W-1:0]   residue
);

	localparam int T_W = sxlt_pkg::GATE_W + sxlt_pkg::MOD_DIGIT;

	logic [sxlt_pkg::MOD_PAD-1:0]   sh_q;
	logic [sxlt_pkg::GATE_W-1:0]    r_q;
	logic [sxlt_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [127:0]                   key_ext;
	logic [T_W-1:0]                 t;

	assign key_ext = {{(128 - sxlt_pkg::KEY_BITS){1'b0}}, key};
	assign done    = (cnt_q == sxlt_pkg::MOD_CNT_W'(sxlt_pkg::MOD_STEPS));
	assign residue = r_q;

	always_comb begin
		t = {r_q, sh_q[sxlt_pkg::MOD_PAD-1 -: sxlt_pkg::MOD_DIGIT]};
		for (int k = sxlt_pkg::MOD_DIGIT - 1; k >= 0; k--) begin
			if (t >= T_W'(sxlt_pkg::NUM_GATES << k)) begin
				t = t - T_W'(sxlt_pkg::NUM_GATES << k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (!done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= key_ext[sxlt_pkg::MOD_PAD-1:0];
			r_q  <= '0;
		end else if (!done) begin
			sh_q <= sh_q << sxlt_pkg::MOD_DIGIT;
			r_q  <= t[sxlt_pkg::GATE_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> design/shared_exclusive_lock_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared/exclusive lock table core
// Keyed lock table with a slot memory, a gate waiter memory and a sequencer.
// ----------------------------------------------------------------------------
// A request transaction is taken when start is high and busy is low. Every
// request gives exactly one result, shown for one cycle with done high; the
// receiver cannot hold it off. The time from one accept to the next is set
// by the scan of every slot through the single read port of the slot
// memory, or by the key residue unit when it needs longer. After reset the
// block clears both memories, one entry a cycle, and keeps busy high until
// the deeper of the two is cleared.
module shared_exclusive_lock_table_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [sxlt_pkg::FUNC_W-1:0]     func,
	input  wire logic [sxlt_pkg::KEY_IN_W-1:0]   resource_key,
	output logic                                 done,
	output logic      [sxlt_pkg::STATUS_W-1:0]   status,
	output logic      [sxlt_pkg::GATE_W-1:0]     gate,
	output logic      [sxlt_pkg::WAIT_W-1:0]     waiters_released,
	output logic                                 entry_freed
);

	localparam int SCB = sxlt_pkg::SHARE_COUNT_BITS;

	sxlt_pkg::state_t     state_q, state_d;
	sxlt_pkg::func_t      func_q;
	logic [sxlt_pkg::KEY_BITS-1:0] key_q, key_in;
	logic [63:0]          key_ext;
	logic                 accept;

	logic [sxlt_pkg::SCAN_W-1:0] scan_q;
	logic                        rd_vld_s1;
	logic [sxlt_pkg::IDX_W-1:0]  rd_idx_s1;
	logic [sxlt_pkg::CLR_W-1:0]  clr_q;

	logic                        found_q, fexcl_q, free_found_q;
	logic [sxlt_pkg::IDX_W-1:0]  fidx_q, free_idx_q;
	logic [SCB-1:0]              fcnt_q;

	logic                        s_we, s_re;
	logic [sxlt_pkg::IDX_W-1:0]  s_waddr, s_raddr;
	sxlt_pkg::slot_word_t        s_wdata, s_rdata;
	logic [sxlt_pkg::SLOT_W-1:0] s_rdata_raw;

	logic                        g_we, g_re;
	logic [sxlt_pkg::GADDR_W-1:0] g_waddr, g_raddr;
	logic [sxlt_pkg::WAIT_W-1:0] g_wdata, g_rdata;

	logic                        mod_done;
	logic [sxlt_pkg::GATE_W-1:0] residue;

	sxlt_pkg::status_t           res_status;
	logic [sxlt_pkg::WAIT_W-1:0] res_rel;
	logic                        res_freed;

	logic                        done_q, freed_q;
	sxlt_pkg::status_t           status_q;
	logic [sxlt_pkg::GATE_W-1:0] gate_q;
	logic [sxlt_pkg::WAIT_W-1:0] rel_q;

	assign key_ext = {32'b0, resource_key};
	assign key_in  = key_ext[sxlt_pkg::KEY_BITS-1:0];
	assign busy    = (state_q != sxlt_pkg::S_IDLE);
	assign accept  = start && (state_q == sxlt_pkg::S_IDLE);
	assign s_rdata = sxlt_pkg::slot_word_t'(s_rdata_raw);

	assign done             = done_q;
	assign status           = status_q;
	assign gate             = gate_q;
	assign waiters_released = rel_q;
	assign entry_freed      = freed_q;

	sxlt_ram #(
		.WIDTH (sxlt_pkg::SLOT_W),
		.DEPTH (sxlt_pkg::ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata_raw)
	);

	sxlt_ram #(
		.WIDTH (sxlt_pkg::WAIT_W),
		.DEPTH (sxlt_pkg::NUM_GATES)
	) u_gate_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (g_re),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	sxlt_gate_mod u_gate_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.key     (key_in),
		.done    (mod_done),
		.residue (residue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sxlt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_we       = 1'b0;
		s_waddr    = '0;
		s_wdata    = '0;
		s_re       = 1'b0;
		s_raddr    = scan_q[sxlt_pkg::IDX_W-1:0];
		g_we       = 1'b0;
		g_waddr    = residue[sxlt_pkg::GADDR_W-1:0];
		g_wdata    = '0;
		g_re       = 1'b0;
		g_raddr    = residue[sxlt_pkg::GADDR_W-1:0];
		res_status = sxlt_pkg::ST_GRANTED;
		res_rel    = '0;
		res_freed  = 1'b0;
		case (state_q)
			sxlt_pkg::S_CLEAR: begin
				s_we    = (clr_q < sxlt_pkg::CLR_W'(sxlt_pkg::ENTRIES));
				s_waddr = clr_q[sxlt_pkg::IDX_W-1:0];
				g_we    = (clr_q < sxlt_pkg::CLR_W'(sxlt_pkg::NUM_GATES));
				g_waddr = clr_q[sxlt_pkg::GADDR_W-1:0];
				if (clr_q == sxlt_pkg::CLR_W'(sxlt_pkg::CLR_DEPTH - 1)) begin
					state_d = sxlt_pkg::S_IDLE;
				end
			end
			sxlt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = sxlt_pkg::S_SCAN;
				end
			end
			sxlt_pkg::S_SCAN: begin
				s_re = (scan_q < sxlt_pkg::SCAN_W'(sxlt_pkg::ENTRIES));
				if ((scan_q == sxlt_pkg::SCAN_W'(sxlt_pkg::ENTRIES)) && mod_done) begin
					g_re    = 1'b1;
					state_d = sxlt_pkg::S_DECIDE;
				end
			end
			sxlt_pkg::S_DECIDE: begin
				state_d = sxlt_pkg::S_IDLE;
				s_wdata.valid = 1'b1;
				s_wdata.key   = key_q;
				s_wdata.excl  = fexcl_q;
				s_wdata.count = fcnt_q;
				s_waddr       = fidx_q;
				case (func_q)
					sxlt_pkg::FN_LOCK_EX, sxlt_pkg::FN_LOCK_SH: begin
						if (!found_q) begin
							if (!free_found_q) begin
								res_status = sxlt_pkg::ST_TABLE_FULL;
							end else begin
								s_we          = 1'b1;
								s_waddr       = free_idx_q;
								s_wdata.excl  = (func_q == sxlt_pkg::FN_LOCK_EX);
								s_wdata.count = (func_q == sxlt_pkg::FN_LOCK_SH) ?
									SCB'(1) : '0;
							end
						end else if (fexcl_q || ((func_q == sxlt_pkg::FN_LOCK_EX) &&
								(fcnt_q != '0))) begin
							res_status = sxlt_pkg::ST_BUSY;
							g_we       = (g_rdata != {sxlt_pkg::WAIT_W{1'b1}});
							g_wdata    = g_rdata + 1'b1;
						end else if (func_q == sxlt_pkg::FN_LOCK_EX) begin
							s_we         = 1'b1;
							s_wdata.excl = 1'b1;
						end else if (fcnt_q == {SCB{1'b1}}) begin
							res_status = sxlt_pkg::ST_SHARE_FULL;
						end else begin
							s_we          = 1'b1;
							s_wdata.count = fcnt_q + 1'b1;
						end
					end
					sxlt_pkg::FN_UNLOCK_EX: begin
						if (!found_q || !fexcl_q) begin
							res_status = sxlt_pkg::ST_NOT_LOCKED;
						end else begin
							s_we      = 1'b1;
							s_wdata   = '0;
							g_we      = 1'b1;
							res_rel   = g_rdata;
							res_freed = 1'b1;
						end
					end
					sxlt_pkg::FN_UNLOCK_SH: begin
						if (!found_q || (fcnt_q == '0)) begin
							res_status = sxlt_pkg::ST_NOT_LOCKED;
						end else if (fcnt_q == SCB'(1)) begin
							s_we      = 1'b1;
							s_wdata   = '0;
							g_we      = 1'b1;
							res_rel   = g_rdata;
							res_freed = 1'b1;
						end else begin
							s_we          = 1'b1;
							s_wdata.count = fcnt_q - 1'b1;
						end
					end
					default: begin
						res_status = sxlt_pkg::ST_NOT_LOCKED;
					end
				endcase
			end
			default: begin
				state_d = sxlt_pkg::S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= (state_q == sxlt_pkg::S_DECIDE);
			if (state_q == sxlt_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				scan_q       <= '0;
				rd_vld_s1    <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == sxlt_pkg::S_SCAN) begin
				rd_vld_s1 <= s_re;
				if (s_re) begin
					scan_q <= scan_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (s_rdata.valid && (s_rdata.key == key_q) && !found_q) begin
						found_q <= 1'b1;
					end
					if (!s_rdata.valid && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
			end else begin
				rd_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= sxlt_pkg::func_t'(func);
			key_q  <= key_in;
		end
		if (state_q == sxlt_pkg::S_SCAN) begin
			rd_idx_s1 <= scan_q[sxlt_pkg::IDX_W-1:0];
			if (rd_vld_s1) begin
				if (s_rdata.valid && (s_rdata.key == key_q) && !found_q) begin
					fidx_q  <= rd_idx_s1;
					fexcl_q <= s_rdata.excl;
					fcnt_q  <= s_rdata.count;
				end
				if (!s_rdata.valid && !free_found_q) begin
					free_idx_q <= rd_idx_s1;
				end
			end
		end
		if (state_q == sxlt_pkg::S_DECIDE) begin
			status_q <= res_status;
			gate_q   <= residue;
			rel_q    <= res_rel;
			freed_q  <= res_freed;
		end
	end

endmodule
`default_nettype wire
